### src/bpcl_pkg.sv
// Package for the BSP point cell locator: operation codes, word types.
// No dependencies.
package bpcl_pkg;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_LOCATE = 2'd1;
	localparam logic [1:0] OP_CACHED = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [9:0]         node_index;
		logic               split_flag;
		logic signed [15:0] cell_number;
		logic [9:0]         child_ahead;
		logic [9:0]         child_behind;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] plane_offset;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] found_cell;
		logic               from_cache;
		logic               status;
	} out_word_t;

endpackage

### src/bpcl_stream_if.sv
// Valid/ready stream interface carrying one payload word.
// The payload type is a parameter; no package dependency.
interface bpcl_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/bsp_point_cell_locator.sv
// Top level of the BSP point cell locator: node memory, walk sequencer, cache.
// Depends on bpcl_pkg and bpcl_stream_if.
//
// channel | dir | payload
// req     | in  | bpcl_pkg::in_word_t (operation, node fields, vector, offset)
// rsp     | out | bpcl_pkg::out_word_t (found_cell, from_cache, status)
//
// A write goes straight to the response. A locate reads the root node, then for
// each split node walked forms three products, one per cycle, on one shared
// 32x32 multiplier, sums them and steps to the child read from the node memory.
// A cached locate first runs the sphere test: a hit answers from the cache, a
// miss goes on to the walk. A child index past the memory is reduced by NODE_COUNT.
// No clearing pass; reset clears control and the cache. A stalled result
// holds in the output register and blocks the next request.
module bsp_point_cell_locator #(
	parameter int NODE_COUNT      = 1024,
	parameter int MAX_WALK_DEPTH  = 64,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	bpcl_stream_if.sink   req,
	bpcl_stream_if.source rsp
);
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int DW = $clog2(MAX_WALK_DEPTH + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_READ = 4'd1, ST_CHK = 4'd2,
		ST_MX = 4'd3, ST_MY = 4'd4, ST_MZ = 4'd5, ST_SUM = 4'd6,
		ST_STEP = 4'd7, ST_CA = 4'd8, ST_CB = 4'd9, ST_CC = 4'd10,
		ST_CD = 4'd11, ST_OUT = 4'd12, ST_WRAP = 4'd13;

	logic [3:0] state_q;
	logic [36:0]  links_mem [NODE_COUNT];
	logic [127:0] geo_mem [NODE_COUNT];
	logic [36:0]  link_q;
	logic [127:0] geo_q;
	logic [AW-1:0] rd_addr;

	bpcl_pkg::in_word_t req_q;
	logic [AW-1:0] node_q;
	logic [9:0] wrap_q;
	logic [DW-1:0] steps_q;
	logic [31:0] least_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] acc_q;
	logic [COORD_FRAC_BITS+1:0] rem_q;
	logic signed [63:0] d_q;

	logic signed [31:0] cpx_q, cpy_q, cpz_q;
	logic [31:0] crad_q;
	logic signed [15:0] ccell_q;
	logic [32:0] da_q, db_q, dc_q;
	logic [65:0] s_q;
	logic cfail_q;

	logic out_valid_q;
	bpcl_pkg::out_word_t out_q;

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready && req.data.operation == bpcl_pkg::OP_WRITE &&
			{22'd0, req.data.node_index} < 32'(NODE_COUNT)) begin
			links_mem[req.data.node_index[AW-1:0]] <= {req.data.split_flag,
				req.data.cell_number, req.data.child_ahead, req.data.child_behind};
			geo_mem[req.data.node_index[AW-1:0]] <= {req.data.plane_offset,
				req.data.vec_z, req.data.vec_y, req.data.vec_x};
		end
		link_q <= links_mem[rd_addr];
		geo_q  <= geo_mem[rd_addr];
	end

	logic [9:0] child;
	logic signed [31:0] dsat;
	logic [31:0] ad;
	always_comb begin
		child = (d_q <= 0) ? link_q[9:0] : link_q[19:10];
		rd_addr = (state_q == ST_STEP) ? AW'(child) : node_q;
		if (d_q > 64'sh7FFFFFFF) dsat = 32'sh7FFFFFFF;
		else if (d_q < -64'sh80000000) dsat = 32'sh80000000;
		else dsat = d_q[31:0];
		ad = dsat[31] ? 32'(-dsat) : 32'(dsat);
		case (state_q)
			ST_MX: begin mul_a = req_q.vec_x; mul_b = geo_q[31:0]; end
			ST_MY: begin mul_a = req_q.vec_y; mul_b = geo_q[63:32]; end
			ST_MZ: begin mul_a = req_q.vec_z; mul_b = geo_q[95:64]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	function automatic logic [32:0] absd(logic signed [31:0] c, logic signed [31:0] p);
		logic signed [32:0] t;
		t = 33'(c) - 33'(p);
		return t[32] ? 33'(-t) : 33'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			cpx_q <= '0; cpy_q <= '0; cpz_q <= '0;
			crad_q <= '0; ccell_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			prod_q <= mul_a * mul_b;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						node_q <= '0;
						steps_q <= '0;
						least_q <= '1;
						out_q <= '0;
						case (req.data.operation)
							bpcl_pkg::OP_LOCATE: state_q <= ST_READ;
							bpcl_pkg::OP_CACHED: state_q <= ST_CA;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_CA: begin
					da_q <= absd(cpx_q, req_q.vec_x);
					db_q <= absd(cpy_q, req_q.vec_y);
					dc_q <= absd(cpz_q, req_q.vec_z);
					state_q <= ST_CB;
				end
				ST_CB: begin
					cfail_q <= crad_q == 0 || da_q >= {1'b0, crad_q} ||
						db_q >= {1'b0, crad_q} || dc_q >= {1'b0, crad_q};
					s_q <= 66'(da_q) * 66'(da_q);
					state_q <= ST_CC;
				end
				ST_CC: begin
					s_q <= s_q + 66'(db_q) * 66'(db_q);
					state_q <= ST_CD;
				end
				ST_CD: begin
					if (!cfail_q && 66'(crad_q) * 66'(crad_q) > s_q + 66'(dc_q) * 66'(dc_q))
						begin
						out_q.found_cell <= ccell_q;
						out_q.from_cache <= 1'b1;
						state_q <= ST_OUT;
					end else state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_CHK;
				ST_CHK: begin
					if (!link_q[36] || !link_q[35]) begin
						out_q.found_cell <= link_q[35:20];
						if (req_q.operation == bpcl_pkg::OP_CACHED) begin
							cpx_q <= req_q.vec_x; cpy_q <= req_q.vec_y;
							cpz_q <= req_q.vec_z;
							crad_q <= least_q; ccell_q <= link_q[35:20];
						end
						state_q <= ST_OUT;
					end else if (32'(steps_q) >= 32'(MAX_WALK_DEPTH)) begin
						out_q.found_cell <= -16'sd1;
						out_q.status <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						steps_q <= steps_q + 1'b1;
						acc_q <= '0;
						rem_q <= '0;
						state_q <= ST_MX;
					end
				end
				ST_MX: state_q <= ST_MY;
				ST_MY, ST_MZ, ST_SUM: begin
					acc_q <= acc_q + (prod_q >>> COORD_FRAC_BITS);
					rem_q <= rem_q + (COORD_FRAC_BITS+2)'(prod_q[COORD_FRAC_BITS-1:0]);
					state_q <= (state_q == ST_SUM) ? ST_STEP :
						(state_q == ST_MY) ? ST_MZ : ST_SUM;
					if (state_q == ST_SUM)
						d_q <= acc_q + (prod_q >>> COORD_FRAC_BITS) +
							$signed(64'((rem_q +
							(COORD_FRAC_BITS+2)'(prod_q[COORD_FRAC_BITS-1:0]))
							>> COORD_FRAC_BITS)) - 64'(signed'(geo_q[127:96]));
				end
				ST_STEP: begin
					if (ad <= least_q) least_q <= ad;
					if ({22'd0, child} < 32'(NODE_COUNT)) begin
						node_q <= rd_addr;
						state_q <= ST_CHK;
					end else begin
						wrap_q <= child;
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if ({22'd0, wrap_q} < 32'(NODE_COUNT)) begin
						node_q <= AW'(wrap_q);
						state_q <= ST_READ;
					end else wrap_q <= wrap_q - 10'(NODE_COUNT);
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### test/tb_bsp_point_cell_locator.sv
// Testbench for bsp_point_cell_locator: builds BSP trees, locates points plain and cached.
// Predicts every result in a scoreboard class and checks it field by field.
// Depends on bpcl_pkg, bpcl_stream_if and the RTL top level.
class cell_locator_board;
	logic [36:0]        links [1024];
	logic signed [31:0] norm_x [1024];
	logic signed [31:0] norm_y [1024];
	logic signed [31:0] norm_z [1024];
	logic signed [31:0] offset [1024];
	logic signed [31:0] cache_x, cache_y, cache_z;
	logic [31:0]        cache_rad;
	logic signed [15:0] cache_cell;
	bpcl_pkg::out_word_t expected_q[$];
	int errors;

	function new();
		foreach (links[i]) begin
			links[i] = '0;
			norm_x[i] = '0;
			norm_y[i] = '0;
			norm_z[i] = '0;
			offset[i] = '0;
		end
		cache_x = '0;
		cache_y = '0;
		cache_z = '0;
		cache_rad = '0;
		cache_cell = '0;
		errors = 0;
	endfunction

	function logic signed [31:0] plane_dist(int n, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		logic signed [65:0] ax, ay, az, bx, by, bz, bo, acc, d;
		ax = px;
		ay = py;
		az = pz;
		bx = norm_x[n];
		by = norm_y[n];
		bz = norm_z[n];
		bo = offset[n];
		acc = ax * bx + ay * by + az * bz;
		d = (acc >>> 16) - bo;
		if (d > 66'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		if (d < -66'sh80000000)
			return 32'sh80000000;
		return d[31:0];
	endfunction

	function bit sphere_hit(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		longint a, b, c;
		logic [67:0] sum, rr, wa, wb, wc, wr;
		a = longint'(cache_x) - longint'(px);
		b = longint'(cache_y) - longint'(py);
		c = longint'(cache_z) - longint'(pz);
		if (a < 0) a = -a;
		if (b < 0) b = -b;
		if (c < 0) c = -c;
		if (cache_rad == 0 || a >= cache_rad || b >= cache_rad || c >= cache_rad)
			return 0;
		wa = a;
		wb = b;
		wc = c;
		wr = cache_rad;
		sum = wa * wa + wb * wb + wc * wc;
		rr = wr * wr;
		return rr > sum;
	endfunction

	function bpcl_pkg::out_word_t locate(bpcl_pkg::in_word_t w);
		bpcl_pkg::out_word_t o;
		int node, steps;
		logic [31:0] least, ad;
		logic signed [31:0] d;
		o = '0;
		if (w.operation == bpcl_pkg::OP_CACHED && sphere_hit(w.vec_x, w.vec_y, w.vec_z)) begin
			o.found_cell = cache_cell;
			o.from_cache = 1'b1;
			return o;
		end
		node = 0;
		steps = 0;
		least = 32'hFFFFFFFF;
		while (links[node][36] && links[node][35]) begin
			if (steps >= 64) begin
				o.found_cell = -16'sd1;
				o.status = 1'b1;
				return o;
			end
			steps++;
			d = plane_dist(node, w.vec_x, w.vec_y, w.vec_z);
			ad = d[31] ? (~d + 32'd1) : d;
			if (ad <= least)
				least = ad;
			node = (d <= 0) ? links[node][9:0] : links[node][19:10];
		end
		o.found_cell = links[node][35:20];
		if (w.operation == bpcl_pkg::OP_CACHED) begin
			cache_x = w.vec_x;
			cache_y = w.vec_y;
			cache_z = w.vec_z;
			cache_rad = least;
			cache_cell = o.found_cell;
		end
		return o;
	endfunction

	function void note_input(bpcl_pkg::in_word_t w);
		bpcl_pkg::out_word_t o;
		o = '0;
		case (w.operation)
			bpcl_pkg::OP_WRITE: begin
				links[w.node_index] = {w.split_flag, w.cell_number, w.child_ahead,
					w.child_behind};
				norm_x[w.node_index] = w.vec_x;
				norm_y[w.node_index] = w.vec_y;
				norm_z[w.node_index] = w.vec_z;
				offset[w.node_index] = w.plane_offset;
			end
			bpcl_pkg::OP_LOCATE, bpcl_pkg::OP_CACHED: o = locate(w);
			default: o = '0;
		endcase
		expected_q.push_back(o);
	endfunction

	function void check_result(bpcl_pkg::out_word_t got);
		bpcl_pkg::out_word_t exp;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected word found_cell=%0d from_cache=%0b status=%0b",
				$time, got.found_cell, got.from_cache, got.status);
			errors++;
			return;
		end
		exp = expected_q.pop_front();
		if (got.found_cell !== exp.found_cell) begin
			$display("%0t: found_cell expected %0d actual %0d", $time, exp.found_cell,
				got.found_cell);
			errors++;
		end
		if (got.from_cache !== exp.from_cache) begin
			$display("%0t: from_cache expected %0b actual %0b", $time, exp.from_cache,
				got.from_cache);
			errors++;
		end
		if (got.status !== exp.status) begin
			$display("%0t: status expected %0b actual %0b", $time, exp.status, got.status);
			errors++;
		end
	endfunction
endclass

module tb_bsp_point_cell_locator;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	bpcl_stream_if #(.T(bpcl_pkg::in_word_t))  req ();
	bpcl_stream_if #(.T(bpcl_pkg::out_word_t)) rsp ();

	cell_locator_board board;
	bit   written [1024];
	int   written_list[$];
	bit   calm;
	bit   hold_long;
	logic signed [31:0] last_x, last_y, last_z;

	bsp_point_cell_locator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_word(bpcl_pkg::in_word_t w);
		if (!calm && $urandom_range(0, 9) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= w;
		do @(posedge clk); while (!req.ready);
		board.note_input(w);
		if (w.operation == bpcl_pkg::OP_WRITE && !written[w.node_index]) begin
			written[w.node_index] = 1'b1;
			written_list.push_back(w.node_index);
		end
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(bit wide);
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return wide ? $signed($urandom) >>> 8 : $signed($urandom) >>> 13;
		endcase
	endfunction

	task automatic put_node(int idx, bit split, logic signed [15:0] cell_id, int ahead,
			int behind, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] off);
		bpcl_pkg::in_word_t w;
		w = '0;
		w.operation = bpcl_pkg::OP_WRITE;
		w.node_index = 10'(idx);
		w.split_flag = split;
		w.cell_number = cell_id;
		w.child_ahead = 10'(ahead);
		w.child_behind = 10'(behind);
		w.vec_x = x;
		w.vec_y = y;
		w.vec_z = z;
		w.plane_offset = off;
		send_word(w);
	endtask

	task automatic find_point(logic [1:0] op, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		bpcl_pkg::in_word_t w;
		w = bpcl_pkg::in_word_t'(186'({$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom}));
		w.cell_number = 16'($urandom);
		w.vec_x = x;
		w.vec_y = y;
		w.vec_z = z;
		w.plane_offset = $urandom;
		w.operation = op;
		if (op == bpcl_pkg::OP_CACHED) begin
			last_x = x;
			last_y = y;
			last_z = z;
		end
		send_word(w);
	endtask

	task automatic random_node();
		int idx;
		bit split;
		logic signed [15:0] cell_id;
		idx = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 1023);
		split = $urandom_range(0, 9) != 0;
		cell_id = ($urandom_range(0, 9) < 7) ? -$signed(16'($urandom_range(1, 32768)))
			: $signed(16'($urandom));
		put_node(idx, split, cell_id,
			written_list[$urandom_range(0, written_list.size() - 1)],
			written_list[$urandom_range(0, written_list.size() - 1)],
			rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(1));
	endtask

	initial begin
		forever begin
			if (hold_long) begin
				rsp.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_long = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	always @(posedge clk)
		if (rsp.valid && rsp.ready)
			board.check_result(rsp.data);

	initial begin
		bpcl_pkg::in_word_t w;
		int pick;
		board = new();
		calm = 1'b0;
		hold_long = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		last_x = '0;
		last_y = '0;
		last_z = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		put_node(1, 0, 16'sd5, 1023, 1023, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh7FFFFFFF);
		put_node(2, 1, 16'sd32767, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000);
		put_node(0, 1, -16'sd1, 1, 2, 32'sh10000, 0, 0, 0);
		find_point(bpcl_pkg::OP_LOCATE, 32'sh10000, 0, 0);
		find_point(bpcl_pkg::OP_LOCATE, 0, 0, 0);
		find_point(bpcl_pkg::OP_LOCATE, -32'sh10000, 0, 0);
		find_point(bpcl_pkg::OP_LOCATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		find_point(bpcl_pkg::OP_LOCATE, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		find_point(bpcl_pkg::OP_CACHED, 32'shA0000, 0, 0);
		find_point(bpcl_pkg::OP_CACHED, 32'shA8000, 32'sh8000, 0);
		find_point(bpcl_pkg::OP_CACHED, -32'shA0000, 0, 0);
		find_point(bpcl_pkg::OP_CACHED, 0, 0, 0);
		find_point(bpcl_pkg::OP_CACHED, 32'sh8000, 0, 0);
		w = '1;
		send_word(w);
		put_node(3, 1, -16'sd32768, 3, 3, 32'sh10000, 0, 0, 0);
		put_node(0, 1, -16'sd2, 3, 3, 32'sh10000, 0, 0, 0);
		find_point(bpcl_pkg::OP_LOCATE, 32'sh10000, 0, 0);
		find_point(bpcl_pkg::OP_CACHED, 32'sh10000, 0, 0);
		put_node(0, 0, 16'sd0, 0, 0, 0, 0, 0, 0);
		find_point(bpcl_pkg::OP_CACHED, 32'sh7FFFFFFF, 0, 0);
		find_point(bpcl_pkg::OP_CACHED, 32'sh80000000, 32'sh7FFFFFFF, 0);
		find_point(bpcl_pkg::OP_LOCATE, 0, 0, 0);
		put_node(0, 1, -16'sd1, 1, 2, 0, 32'sh10000, 32'sh10000, 32'sh10000);

		for (int i = 0; i < 730; i++) begin
			if (i == 300)
				hold_long = 1'b1;
			if (i == 640)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 25)
				random_node();
			else if (pick < 28) begin
				w = bpcl_pkg::in_word_t'(186'({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom}));
				w.vec_x = $urandom;
				w.operation = bpcl_pkg::OP_UNUSED;
				send_word(w);
			end else if (pick < 58)
				find_point(bpcl_pkg::OP_LOCATE, rand_coord(1), rand_coord(1),
					rand_coord(1));
			else if (pick < 80)
				find_point(bpcl_pkg::OP_CACHED, last_x + ($signed($urandom) >>> 14),
					last_y + ($signed($urandom) >>> 14), last_z + ($signed($urandom) >>> 14));
			else
				find_point(bpcl_pkg::OP_CACHED, rand_coord(1), rand_coord(1),
					rand_coord(1));
		end
		req.valid <= 1'b0;

		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
